[hdl/lcd_pkg.sv]
// ----------------------------------------------------------------------------
// lcd_pkg: shared types and constants for the LRU cell tag directory
// Sizes of the directory, item layouts for both channels, and the entry
// and control layouts that the recency chain cells use.
// ----------------------------------------------------------------------------
package lcd_pkg;

  // Directory geometry
  localparam int CACHE_ENTRIES = 64;
  localparam int ID_BITS       = 20;
  localparam int SLOT_W        = $clog2(CACHE_ENTRIES);
  localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

  // Fixed field widths of the item layouts
  localparam int CELL_ID_W  = 20;
  localparam int OUT_SLOT_W = 6;
  localparam int OCC_W      = 7;
  localparam int HITS_W     = 32;

  // Item kinds
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [CELL_ID_W-1:0] cell_id;
  } in_t;

  typedef struct packed {
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  evicted_valid;
    logic [CELL_ID_W-1:0]  evicted_id;
    logic [OCC_W-1:0]      occupancy;
    logic [HITS_W-1:0]     hit_total;
  } out_t;

  // One directory entry as it travels down the chain
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [ID_BITS-1:0] tag;
  } entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic clear;
    logic load;
  } cell_ctrl_t;

endpackage

[hdl/lcd_cell.sv]
// ----------------------------------------------------------------------------
// lcd_cell: one position of the recency chain
// Holds the entry at one recency rank, compares its tag against the
// broadcast id and takes its left neighbor's entry when told to shift.
// ----------------------------------------------------------------------------
module lcd_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lcd_pkg::cell_ctrl_t        ctrl,
  input  lcd_pkg::entry_t            left_i,
  input  logic [lcd_pkg::ID_BITS-1:0] id_i,
  output lcd_pkg::entry_t            entry_o,
  output logic                       match_o
);

  logic                        valid_r;
  logic [lcd_pkg::SLOT_W-1:0]  slot_r;
  logic [lcd_pkg::ID_BITS-1:0] tag_r;

  // Valid bit: clear on reset or clear item, else follow the shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.load) begin
      valid_r <= left_i.valid;
    end
  end

  // Payload: advance from the left neighbor
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot_r <= left_i.slot;
      tag_r  <= left_i.tag;
    end
  end

  // Tag compare, only on a live entry
  assign match_o = valid_r && (tag_r == id_i);

  assign entry_o.valid = valid_r;
  assign entry_o.slot  = slot_r;
  assign entry_o.tag   = tag_r;

endmodule

[hdl/lru_cell_tag_directory.sv]
// ----------------------------------------------------------------------------
// lru_cell_tag_directory: fully associative LRU tag directory for cell ids
// A chain of cells ordered by recency, head cell most recent. An access
// item compares all cells at once, then shifts the chain so the accessed
// id lands in the head cell; a miss on a full chain drops the tail entry.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                    | Handshake
//  --------+--------------------------+-----------------------------------
//  input   | start, busy, in_data     | taken when start && !busy
//  result  | out_valid, out_data      | one-cycle strobe, no back-pressure
//
//  An access item passes through S_LOOK, the parallel tag compare across the
//  chain, and S_UPD, the chain shift and result register; the strobe follows
//  with busy already low, so the next item is taken at the edge that ends
//  the strobe. A new item is taken only once busy has dropped. A clear item
//  skips S_UPD: its strobe follows S_LOOK. Reset clears every valid bit at
//  once; no clearing pass. The receiver cannot stall, so nothing is ever
//  held back.
//
module lru_cell_tag_directory (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lcd_pkg::in_t  in_data,
  output logic          out_valid,
  output lcd_pkg::out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  localparam int N = lcd_pkg::CACHE_ENTRIES;

  state_t                       state_r;
  logic                         kind_r;
  logic [lcd_pkg::ID_BITS-1:0]  id_r;
  logic [N-1:0]                 match_r;
  logic [lcd_pkg::CNT_W-1:0]    count_r;
  logic [lcd_pkg::HITS_W-1:0]   hits_r;
  logic                         out_valid_r;
  lcd_pkg::out_t                out_data_r;

  lcd_pkg::entry_t              chain [N];
  lcd_pkg::cell_ctrl_t          ctrl  [N];
  logic [N-1:0]                 match;
  lcd_pkg::entry_t              head;

  logic                         hit_any;
  logic                         full;
  logic [lcd_pkg::SLOT_W-1:0]   hit_idx;
  logic [lcd_pkg::SLOT_W-1:0]   hit_slot;
  logic [lcd_pkg::SLOT_W-1:0]   new_slot;
  logic                         do_clear;
  logic                         do_update;

  // Recency chain
  for (genvar j = 0; j < N; j++) begin : g_cell
    lcd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl[j]),
      .left_i  ((j == 0) ? head : chain[(j == 0) ? 0 : j - 1]),
      .id_i    (id_r),
      .entry_o (chain[j]),
      .match_o (match[j])
    );
  end

  // Locate the hit cell and its slot
  always_comb begin
    hit_idx  = '0;
    hit_slot = '0;
    for (int j = 0; j < N; j++) begin
      if (match_r[j]) begin
        hit_idx  = hit_idx | lcd_pkg::SLOT_W'(j);
        hit_slot = hit_slot | chain[j].slot;
      end
    end
  end

  assign hit_any   = |match_r;
  assign full      = (count_r == lcd_pkg::CNT_W'(N));
  assign do_clear  = (state_r == S_LOOK) && (kind_r == lcd_pkg::KIND_CLEAR);
  assign do_update = (state_r == S_UPD);

  // Slot for the id entering the head: reuse on hit or eviction, else next free
  always_comb begin
    priority if (hit_any) begin
      new_slot = hit_slot;
    end else if (full) begin
      new_slot = chain[N-1].slot;
    end else begin
      new_slot = lcd_pkg::SLOT_W'(count_r);
    end
  end

  assign head.valid = 1'b1;
  assign head.slot  = new_slot;
  assign head.tag   = id_r;

  // Shift cells up to the hit position, or the whole chain on a miss
  always_comb begin
    for (int j = 0; j < N; j++) begin
      ctrl[j].clear = do_clear;
      ctrl[j].load  = do_update &&
                      (!hit_any || (lcd_pkg::SLOT_W'(j) <= hit_idx));
    end
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= lcd_pkg::KIND_ACCESS;
      id_r        <= '0;
      match_r     <= '0;
      count_r     <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            kind_r  <= in_data.kind;
            id_r    <= lcd_pkg::ID_BITS'(in_data.cell_id);
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (kind_r == lcd_pkg::KIND_CLEAR) begin
            count_r     <= '0;
            hits_r      <= '0;
            out_data_r  <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            match_r <= match;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          out_data_r.hit  <= hit_any;
          out_data_r.slot <= lcd_pkg::OUT_SLOT_W'(new_slot);
          if (hit_any) begin
            out_data_r.evicted_valid <= 1'b0;
            out_data_r.evicted_id    <= '0;
            out_data_r.occupancy     <= lcd_pkg::OCC_W'(count_r);
            if (hits_r != '1) begin
              hits_r               <= hits_r + 1'b1;
              out_data_r.hit_total <= hits_r + 1'b1;
            end else begin
              out_data_r.hit_total <= hits_r;
            end
          end else begin
            out_data_r.hit_total <= hits_r;
            if (full) begin
              out_data_r.evicted_valid <= 1'b1;
              out_data_r.evicted_id    <= lcd_pkg::CELL_ID_W'(chain[N-1].tag);
              out_data_r.occupancy     <= lcd_pkg::OCC_W'(count_r);
            end else begin
              out_data_r.evicted_valid <= 1'b0;
              out_data_r.evicted_id    <= '0;
              out_data_r.occupancy     <= lcd_pkg::OCC_W'(count_r + 1'b1);
              count_r                  <= count_r + 1'b1;
            end
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/lcd_checker.sv]
// ----------------------------------------------------------------------------
// lcd_checker: port-level checks for the LRU cell tag directory
// Watches the item handshake and the result fields over time.
// ----------------------------------------------------------------------------
module lcd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input lcd_pkg::in_t  in_data,
  input logic          out_valid,
  input lcd_pkg::out_t out_data
);

  // Occupancy never exceeds the directory size
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.occupancy <= lcd_pkg::OCC_W'(lcd_pkg::CACHE_ENTRIES)))
    else $error("occupancy beyond directory size");

  // Eviction only on a miss with a full directory
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.evicted_valid) |->
      (!out_data.hit &&
       out_data.occupancy == lcd_pkg::OCC_W'(lcd_pkg::CACHE_ENTRIES)))
    else $error("eviction without a full miss");

  // A hit reports no eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |->
      (!out_data.evicted_valid && out_data.evicted_id == '0))
    else $error("hit reported an eviction");

  // A clear item yields an all-zero result strobe after it is taken
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind == lcd_pkg::KIND_CLEAR) |->
      ##2 (out_valid && out_data == '0))
    else $error("clear item gave no zero result");

  // An access item always gives a result strobe after it is taken
  a_access_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind == lcd_pkg::KIND_ACCESS) |-> ##3 out_valid)
    else $error("access item gave no result");

endmodule

bind lru_cell_tag_directory lcd_checker u_lcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU cell tag directory
// Sends access and clear items through the start/busy handshake. A shadow
// directory with recency ranks predicts every result. Each strobed result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          ENTRIES  = lcd_pkg::CACHE_ENTRIES;
  localparam int          IN_W     = $bits(lcd_pkg::in_t);
  localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  lcd_pkg::in_t  in_data;
  logic          out_valid;
  lcd_pkg::out_t out_data;

  lru_cell_tag_directory dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Shadow copy of the directory
  logic [lcd_pkg::ID_BITS-1:0] shadow_tag   [ENTRIES];
  logic                        shadow_valid [ENTRIES];
  int unsigned                 shadow_rank  [ENTRIES];
  int unsigned                 shadow_count;
  logic [31:0]                 shadow_hits;

  lcd_pkg::out_t lookups_due[$];
  int            error_count = 0;
  bit            no_gaps     = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Empty the shadow directory, as reset and clear items do
  function automatic void wipe_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
    shadow_count = 0;
    shadow_hits  = '0;
  endfunction

  // Age every valid entry more recent than limit by one step
  function automatic void age_entries(int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_rank[i] < limit) shadow_rank[i]++;
    end
  endfunction

  // Predict the result of one item and update the shadow directory
  function automatic lcd_pkg::out_t lookup_cell(lcd_pkg::in_t item);
    lcd_pkg::out_t               res;
    logic [lcd_pkg::ID_BITS-1:0] id;
    int                          idx;
    bit                          found;
    int unsigned                 worst;
    res   = '0;
    id    = item.cell_id[lcd_pkg::ID_BITS-1:0];
    idx   = 0;
    found = 0;
    worst = 0;
    if (item.kind == lcd_pkg::KIND_CLEAR) begin
      wipe_shadow();
      return res;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && shadow_valid[i] && shadow_tag[i] == id) begin
        found = 1;
        idx   = i;
      end
    end
    if (found) begin
      // Hit: promote the entry, count it
      age_entries(shadow_rank[idx]);
      shadow_rank[idx] = 0;
      if (shadow_hits != HITS_MAX) shadow_hits++;
    end else if (shadow_count < ENTRIES) begin
      // Miss with room: take the lowest free entry
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!shadow_valid[i]) idx = i;
      end
      age_entries(ENTRIES);
      shadow_valid[idx] = 1'b1;
      shadow_tag[idx]   = id;
      shadow_rank[idx]  = 0;
      shadow_count++;
    end else begin
      // Miss on a full directory: evict the least recent entry
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_valid[i] && shadow_rank[i] >= worst) begin
          worst = shadow_rank[i];
          idx   = i;
        end
      end
      res.evicted_valid = 1'b1;
      res.evicted_id    = lcd_pkg::CELL_ID_W'(shadow_tag[idx]);
      age_entries(shadow_rank[idx]);
      shadow_tag[idx]  = id;
      shadow_rank[idx] = 0;
    end
    res.hit       = found;
    res.slot      = lcd_pkg::OUT_SLOT_W'(idx);
    res.occupancy = lcd_pkg::OCC_W'(shadow_count);
    res.hit_total = shadow_hits;
    return res;
  endfunction

  // Idle cycles between items: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic lcd_pkg::in_t access_item(logic [lcd_pkg::CELL_ID_W-1:0] id);
    lcd_pkg::in_t item;
    item.kind    = lcd_pkg::KIND_ACCESS;
    item.cell_id = id;
    return item;
  endfunction

  function automatic lcd_pkg::in_t clear_item();
    lcd_pkg::in_t item;
    item.kind    = lcd_pkg::KIND_CLEAR;
    item.cell_id = lcd_pkg::CELL_ID_W'($urandom);
    return item;
  endfunction

  // Offer one item, hold it until taken, then idle for a random gap.
  // Start stays high into the next item when the gap is zero.
  task automatic send_item(lcd_pkg::in_t item);
    int n;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    lookups_due = {lookups_due, lookup_cell(item)};
    n = gap_len();
    if (n > 0) begin
      start   <= 1'b0;
      in_data <= lcd_pkg::in_t'(IN_W'($urandom));
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the sender off until every pending result has come back
  task automatic drain_results();
    if (lookups_due.size() != 0) begin
      start <= 1'b0;
      while (lookups_due.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_item(clear_item());
    send_item(access_item(20'h00000));
    send_item(access_item(20'hFFFFF));
    send_item(access_item(20'h00000));
    send_item(access_item(20'hFFFFF));
    send_item(access_item(20'h55555));
    send_item(access_item(20'hAAAAA));
    send_item(access_item(20'h55555));
    send_item(access_item(20'h00000));
    send_item('{kind: lcd_pkg::KIND_CLEAR, cell_id: 20'hFFFFF});
    send_item(access_item(20'hFFFFF));
    send_item(access_item(20'h00000));
    send_item(access_item(20'hFFFFF));
    send_item('{kind: lcd_pkg::KIND_CLEAR, cell_id: 20'h00000});
    send_item(access_item(20'h00000));
  endtask

  // Fill every entry, then force evictions and hits at both recency ends
  task automatic test_fill_and_evict();
    logic [lcd_pkg::CELL_ID_W-1:0] base;
    logic [lcd_pkg::CELL_ID_W-1:0] step;
    base = lcd_pkg::CELL_ID_W'($urandom);
    step = lcd_pkg::CELL_ID_W'($urandom) | 20'h1;
    send_item(clear_item());
    for (int i = 0; i < ENTRIES; i++) begin
      send_item(access_item(base + lcd_pkg::CELL_ID_W'(i) * step));
    end
    drain_results();
    // Oldest entry hit, then the newest
    send_item(access_item(base));
    send_item(access_item(base + lcd_pkg::CELL_ID_W'(ENTRIES - 1) * step));
    for (int i = 0; i < 20; i++) begin
      send_item(access_item(base + lcd_pkg::CELL_ID_W'(ENTRIES + i) * step));
    end
    send_item(access_item(base));
    send_item(access_item(base + step));
  endtask

  // Accesses drawn from a pool of ids, with an occasional clear
  task automatic test_working_set(int count, int pool_size);
    logic [lcd_pkg::CELL_ID_W-1:0] pool[$];
    pool.delete();
    for (int i = 0; i < pool_size; i++) begin
      pool = {pool, lcd_pkg::CELL_ID_W'($urandom)};
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) send_item(clear_item());
      else send_item(access_item(pool[$urandom_range(0, pool_size - 1)]));
    end
  endtask

  // Cycle through one id more than the directory holds, back to back
  task automatic test_thrash(int rounds);
    logic [lcd_pkg::CELL_ID_W-1:0] pool[$];
    pool.delete();
    for (int i = 0; i <= ENTRIES; i++) begin
      pool = {pool, lcd_pkg::CELL_ID_W'($urandom)};
    end
    no_gaps = 1;
    for (int r = 0; r < rounds; r++) begin
      foreach (pool[i]) send_item(access_item(pool[i]));
    end
    no_gaps = 0;
  endtask

  // Fully random ids and kinds
  task automatic test_noise(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(clear_item());
      else send_item(access_item(lcd_pkg::CELL_ID_W'($urandom)));
    end
  endtask

  // Compare one field of a result
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Match every strobed result against the oldest prediction
  always @(posedge clk) begin
    lcd_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (lookups_due.size() == 0) begin
        $display("%0t: result with no item pending, actual %0h", $time, out_data);
        error_count++;
      end else begin
        want = lookups_due.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_data.hit));
        check_field("slot", 32'(want.slot), 32'(out_data.slot));
        check_field("evicted_valid", 32'(want.evicted_valid),
                    32'(out_data.evicted_valid));
        check_field("evicted_id", 32'(want.evicted_id), 32'(out_data.evicted_id));
        check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
        check_field("hit_total", want.hit_total, out_data.hit_total);
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    wipe_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_evict();
    test_working_set(250, 48);
    test_working_set(250, 64);
    test_thrash(3);
    test_working_set(250, 72);
    test_working_set(250, 160);
    test_noise(200);

    // Let the last results arrive, then give the verdict
    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0 && lookups_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/lcd_pkg.sv
hdl/lcd_cell.sv
hdl/lru_cell_tag_directory.sv
hdl/lcd_checker.sv
tb/testbench.sv
